// ===== hw/rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP responder with cache
// Holds the field widths, the opcode and result kind codes, the register map,
// the controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam int unsigned MacW  = 48;
  localparam int unsigned IpW   = 32;
  localparam int unsigned OpW   = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 64;

  // Byte address bit that selects between the two 64-bit registers.
  localparam int unsigned RegSelBit = 3;

  localparam logic [OpW-1:0] OP_REQUEST = 16'd1;
  localparam logic [OpW-1:0] OP_REPLY   = 16'd2;

  typedef enum logic [0:0] {
    REG_LOCAL_IP  = 1'b0,
    REG_LOCAL_MAC = 1'b1
  } reg_sel_e;

  typedef enum logic [KindW-1:0] {
    KIND_DROP    = 3'd0,
    KIND_REPLY   = 3'd1,
    KIND_LEARNED = 3'd2,
    KIND_KNOWN   = 3'd3,
    KIND_FULL    = 3'd4,
    KIND_HIT     = 3'd5,
    KIND_MISS    = 3'd6,
    KIND_OTHER   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECIDE = 2'd1,
    ST_SCAN   = 2'd2,
    ST_EMIT   = 2'd3
  } state_e;

  typedef struct packed {
    logic  capture;   // latch the input beat and restart the scan
    logic  scan;      // issue the next cache read
    logic  load_out;  // load the output register
    logic  learn;     // append the sender to the cache
    kind_e kind;      // kind of the result being loaded
  } dp_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic tip_match;
    logic op_request;
    logic op_reply;
    logic match;
    logic exhausted;
    logic full;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl: controller of the ARP responder with cache
// Sequences one item at a time: capture, classify, scan the cache where
// needed, then hand the result kind to the datapath's output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire arpc_pkg::dp_sts_t sts_i,
  output arpc_pkg::dp_cmd_t      cmd_o
);

  arpc_pkg::state_e state_q, state_d;
  arpc_pkg::kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpc_pkg::ST_IDLE;
      kind_q  <= arpc_pkg::KIND_DROP;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    kind_d         = kind_q;
    in_stall_o     = 1'b1;
    cmd_o          = '0;
    cmd_o.kind     = kind_q;
    unique case (state_q)
      arpc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = arpc_pkg::ST_DECIDE;
        end
      end
      arpc_pkg::ST_DECIDE: begin
        if (sts_i.is_lookup) begin
          state_d = arpc_pkg::ST_SCAN;
        end else if (!sts_i.tip_match) begin
          kind_d  = arpc_pkg::KIND_DROP;
          state_d = arpc_pkg::ST_EMIT;
        end else if (sts_i.op_request) begin
          kind_d  = arpc_pkg::KIND_REPLY;
          state_d = arpc_pkg::ST_EMIT;
        end else if (sts_i.op_reply) begin
          state_d = arpc_pkg::ST_SCAN;
        end else begin
          kind_d  = arpc_pkg::KIND_OTHER;
          state_d = arpc_pkg::ST_EMIT;
        end
      end
      arpc_pkg::ST_SCAN: begin
        // Stop reading on a match so the read data stays for the result.
        cmd_o.scan = !sts_i.match;
        if (sts_i.match) begin
          kind_d  = sts_i.is_lookup ? arpc_pkg::KIND_HIT : arpc_pkg::KIND_KNOWN;
          state_d = arpc_pkg::ST_EMIT;
        end else if (sts_i.exhausted) begin
          if (sts_i.is_lookup) begin
            kind_d = arpc_pkg::KIND_MISS;
          end else if (sts_i.full) begin
            kind_d = arpc_pkg::KIND_FULL;
          end else begin
            kind_d = arpc_pkg::KIND_LEARNED;
          end
          state_d = arpc_pkg::ST_EMIT;
        end
      end
      arpc_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.learn    = (kind_q == arpc_pkg::KIND_LEARNED);
          state_d        = arpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arpc_dp.sv =====
// ----------------------------------------------------------------------------
// arpc_dp: datapath of the ARP responder with cache
// Holds the configuration registers, the captured input beat, the cache
// memory with its fill count and scan pointer, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_dp #(
  parameter int unsigned CacheEntries = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [arpc_pkg::AddrW-1:0]    paddr,
  input  wire logic [arpc_pkg::DataW-1:0]    pwdata,
  output logic      [arpc_pkg::DataW-1:0]    prdata,
  // Input payload
  input  wire logic                          mode_i,
  input  wire logic [arpc_pkg::OpW-1:0]      opcode_i,
  input  wire logic [arpc_pkg::MacW-1:0]     sender_mac_i,
  input  wire logic [arpc_pkg::IpW-1:0]      sender_ip_i,
  input  wire logic [arpc_pkg::IpW-1:0]      target_ip_i,
  input  wire logic [arpc_pkg::IpW-1:0]      lookup_ip_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [arpc_pkg::KindW-1:0]    kind_o,
  output logic      [arpc_pkg::MacW-1:0]     reply_dst_mac_o,
  output logic      [arpc_pkg::MacW-1:0]     reply_src_mac_o,
  output logic      [arpc_pkg::IpW-1:0]      reply_sender_ip_o,
  output logic      [arpc_pkg::IpW-1:0]      reply_target_ip_o,
  output logic      [arpc_pkg::MacW-1:0]     found_mac_o,
  // Controller link
  input  wire arpc_pkg::dp_cmd_t             cmd_i,
  output arpc_pkg::dp_sts_t                  sts_o
);

  localparam int unsigned CntW  = $clog2(CacheEntries + 1);
  localparam int unsigned IdxW  = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned EntW  = arpc_pkg::IpW + arpc_pkg::MacW;
  localparam logic [CntW-1:0] CntMax = CntW'(CacheEntries);

  // Configuration registers.
  logic [arpc_pkg::IpW-1:0]  local_ip_q;
  logic [arpc_pkg::MacW-1:0] local_mac_q;
  logic                      cfg_wr;
  arpc_pkg::reg_sel_e        reg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = arpc_pkg::reg_sel_e'(paddr[arpc_pkg::RegSelBit]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        arpc_pkg::REG_LOCAL_IP:  local_ip_q  <= pwdata[arpc_pkg::IpW-1:0];
        arpc_pkg::REG_LOCAL_MAC: local_mac_q <= pwdata[arpc_pkg::MacW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      arpc_pkg::REG_LOCAL_IP:
        prdata = {{(arpc_pkg::DataW - arpc_pkg::IpW){1'b0}}, local_ip_q};
      arpc_pkg::REG_LOCAL_MAC:
        prdata = {{(arpc_pkg::DataW - arpc_pkg::MacW){1'b0}}, local_mac_q};
      default: prdata = '0;
    endcase
  end

  // Captured input beat.
  logic                      mode_q;
  logic [arpc_pkg::OpW-1:0]  opcode_q;
  logic [arpc_pkg::MacW-1:0] smac_q;
  logic [arpc_pkg::IpW-1:0]  sip_q;
  logic [arpc_pkg::IpW-1:0]  tip_q;
  logic [arpc_pkg::IpW-1:0]  lip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      opcode_q <= opcode_i;
      smac_q   <= sender_mac_i;
      sip_q    <= sender_ip_i;
      tip_q    <= target_ip_i;
      lip_q    <= lookup_ip_i;
    end
  end

  // Slots are never freed, so the valid slots are always 0 .. count-1 and the
  // fill count stands in for per-slot valid bits.
  logic [EntW-1:0]          mem_q [CacheEntries];
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          idx_q;
  logic                     rvalid_q;
  logic [arpc_pkg::IpW-1:0]  rd_ip_q;
  logic [arpc_pkg::MacW-1:0] rd_mac_q;
  logic                     issue;
  logic [arpc_pkg::IpW-1:0]  key;

  assign issue = cmd_i.scan && (idx_q < count_q);
  assign key   = mode_q ? lip_q : sip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.learn) begin
      mem_q[count_q[IdxW-1:0]] <= {sip_q, smac_q};
    end
    if (issue) begin
      {rd_ip_q, rd_mac_q} <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.learn) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.capture) begin
        idx_q    <= '0;
        rvalid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rvalid_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CntW'(1);
        end
      end
    end
  end

  // Output register.
  logic out_valid_q;
  logic is_reply;
  logic is_hit;

  assign is_reply = (cmd_i.kind == arpc_pkg::KIND_REPLY);
  assign is_hit   = (cmd_i.kind == arpc_pkg::KIND_HIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kind_o            <= cmd_i.kind;
      reply_dst_mac_o   <= is_reply ? smac_q      : '0;
      reply_src_mac_o   <= is_reply ? local_mac_q : '0;
      reply_sender_ip_o <= is_reply ? tip_q       : '0;
      reply_target_ip_o <= is_reply ? sip_q       : '0;
      found_mac_o       <= is_hit   ? rd_mac_q    : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.is_lookup  = mode_q;
  assign sts_o.tip_match  = (tip_q == local_ip_q);
  assign sts_o.op_request = (opcode_q == arpc_pkg::OP_REQUEST);
  assign sts_o.op_reply   = (opcode_q == arpc_pkg::OP_REPLY);
  assign sts_o.match      = rvalid_q && (rd_ip_q == key);
  assign sts_o.exhausted  = (idx_q == count_q) && !rvalid_q;
  assign sts_o.full       = (count_q == CntMax);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ===== hw/rtl/arp_responder_with_cache_core.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache_core: ARP responder with a bounded ARP cache
// Answers ARP requests for the local address, learns senders of ARP replies
// into a small cache and serves cache lookups.
//
//   Channel   Direction  Handshake                      Beat
//   input     in         in_valid_i / in_stall_o        ARP packet or lookup
//   output    out        out_valid_o / out_stall_i      one result per item
//   config    in/out     psel, penable, pwrite, pready  local_ip, local_mac
//
// An item that needs no cache access goes from the decide state straight to the
// emit state. A lookup or a reply to the local address scans the filled cache
// slots one per cycle through the single read port.
// One item is in flight at a time; the next is accepted when the result has
// been loaded, even if the output beat is still stalled.
// Reset clears the configuration registers and empties the cache at once.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_responder_with_cache_core #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [arpc_pkg::AddrW-1:0]    paddr,
  input  wire logic [arpc_pkg::DataW-1:0]    pwdata,
  output logic      [arpc_pkg::DataW-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [arpc_pkg::OpW-1:0]      opcode_i,
  input  wire logic [arpc_pkg::MacW-1:0]     sender_mac_i,
  input  wire logic [arpc_pkg::IpW-1:0]      sender_ip_i,
  input  wire logic [arpc_pkg::IpW-1:0]      target_ip_i,
  input  wire logic [arpc_pkg::IpW-1:0]      lookup_ip_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [arpc_pkg::KindW-1:0]    kind_o,
  output logic      [arpc_pkg::MacW-1:0]     reply_dst_mac_o,
  output logic      [arpc_pkg::MacW-1:0]     reply_src_mac_o,
  output logic      [arpc_pkg::IpW-1:0]      reply_sender_ip_o,
  output logic      [arpc_pkg::IpW-1:0]      reply_target_ip_o,
  output logic      [arpc_pkg::MacW-1:0]     found_mac_o
);

  arpc_pkg::dp_cmd_t cmd;
  arpc_pkg::dp_sts_t sts;

  assign pready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .CacheEntries (CACHE_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .mode_i            (mode_i),
    .opcode_i          (opcode_i),
    .sender_mac_i      (sender_mac_i),
    .sender_ip_i       (sender_ip_i),
    .target_ip_i       (target_ip_i),
    .lookup_ip_i       (lookup_ip_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .reply_dst_mac_o   (reply_dst_mac_o),
    .reply_src_mac_o   (reply_src_mac_o),
    .reply_sender_ip_o (reply_sender_ip_o),
    .reply_target_ip_o (reply_target_ip_o),
    .found_mac_o       (found_mac_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks of the ARP responder with cache
// Watches the top-level ports and flags results whose unused fields are not
// zero, lost output beats and items accepted back to back.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [arpc_pkg::KindW-1:0] kind_o,
  input wire logic [arpc_pkg::MacW-1:0]  reply_dst_mac_o,
  input wire logic [arpc_pkg::MacW-1:0]  reply_src_mac_o,
  input wire logic [arpc_pkg::IpW-1:0]   reply_sender_ip_o,
  input wire logic [arpc_pkg::IpW-1:0]   reply_target_ip_o,
  input wire logic [arpc_pkg::MacW-1:0]  found_mac_o
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // Reply fields are zero unless the result is a reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != arpc_pkg::KIND_REPLY) |->
      (reply_dst_mac_o == '0) && (reply_src_mac_o == '0) &&
      (reply_sender_ip_o == '0) && (reply_target_ip_o == '0))
    else $error("reply fields set on a non-reply result");

  // The found MAC is zero unless the lookup hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != arpc_pkg::KIND_HIT) |-> (found_mac_o == '0))
    else $error("found MAC set on a result other than a hit");

  // An accepted item holds off the next one in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted in two consecutive cycles");

endmodule

bind arp_responder_with_cache_core arpc_checker u_arpc_checker (.*);

`default_nettype wire
